// ===== hw/rtl/wqpc_pkg.sv =====
// Shared constants, types and register indexes for the water quality pump controller.
package wqpc_pkg;

  localparam int unsigned TempW   = 12;
  localparam int unsigned AdcW    = 12;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DutyW   = 8;
  localparam int unsigned PhW     = 13;
  localparam int unsigned ThreshW = 8;
  localparam int unsigned DurW    = 20;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 20;

  localparam logic [CfgIdxW-1:0] CfgPwmThreshold = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFillDuration = 1'b1;

  localparam logic [ThreshW-1:0] ThreshReset = 8'd20;
  localparam logic [DurW-1:0]    DurReset    = 20'd10000;

  localparam logic signed [TempW-1:0] TempColdLo = 12'sd256;
  localparam logic signed [TempW-1:0] TempColdHi = 12'sd416;
  localparam logic signed [TempW-1:0] TempHotLo  = 12'sd480;
  localparam logic signed [TempW-1:0] TempHotHi  = 12'sd544;

  localparam logic [PhW-1:0] PhAcidLo = 13'd1152;
  localparam logic [PhW-1:0] PhAcidHi = 13'd1664;
  localparam logic [PhW-1:0] PhBaseLo = 13'd1920;
  localparam logic [PhW-1:0] PhBaseHi = 13'd2176;

  localparam logic [PhW-1:0] PhOffsetQ8 = 13'd5348;
  localparam logic [15:0]    PhSlopeQ15 = 16'd37557;

  localparam logic [DutyW-1:0] FullScale = 8'd255;

  typedef struct packed {
    logic [DutyW-1:0] cooling;
    logic [DutyW-1:0] warming;
    logic [DutyW-1:0] acid;
    logic [DutyW-1:0] alkali;
  } duty_t;

endpackage

// ===== hw/rtl/wqpc_calc.sv =====
// pH conversion, trapezoid memberships and threshold gating for one sample.
module wqpc_calc (
  input  logic signed [wqpc_pkg::TempW-1:0]   temp_i,
  input  logic        [wqpc_pkg::AdcW-1:0]    adc_i,
  input  logic        [wqpc_pkg::ThreshW-1:0] threshold_i,
  output wqpc_pkg::duty_t                     duty_o,
  output logic        [wqpc_pkg::PhW-1:0]     ph_o
);

  logic [27:0] ph_prod;
  logic [12:0] ph_drop;

  logic [5:0]  hot_x;
  logic [13:0] hot_prod;
  logic [7:0]  hot_mu;

  logic [7:0]  cold_x;
  logic [12:0] cold_prod;
  logic [7:0]  cold_mu;

  logic [7:0]  base_x;
  logic [15:0] base_prod;
  logic [7:0]  base_mu;

  logic [8:0]  acid_x;
  logic [16:0] acid_prod;
  logic [7:0]  acid_mu;

  function automatic logic [wqpc_pkg::DutyW-1:0] gate_duty(
    input logic [wqpc_pkg::DutyW-1:0]   mu,
    input logic [wqpc_pkg::ThreshW-1:0] thr
  );
    return (mu > thr) ? mu : '0;
  endfunction

  assign ph_prod = 28'(adc_i) * 28'(wqpc_pkg::PhSlopeQ15);
  assign ph_drop = ph_prod[27:15];
  assign ph_o    = wqpc_pkg::PhOffsetQ8 - ph_drop;

  // hot: 255/64 per step
  assign hot_x    = 6'(temp_i - wqpc_pkg::TempHotLo);
  assign hot_prod = 14'(hot_x) * 14'd255;
  always_comb begin
    if (temp_i <= wqpc_pkg::TempHotLo) begin
      hot_mu = '0;
    end else if (temp_i >= wqpc_pkg::TempHotHi) begin
      hot_mu = wqpc_pkg::FullScale;
    end else begin
      hot_mu = hot_prod[13:6];
    end
  end

  // cold: 255/160 reduces to 51/32
  assign cold_x    = 8'(wqpc_pkg::TempColdHi - temp_i);
  assign cold_prod = 13'(cold_x) * 13'd51;
  always_comb begin
    if (temp_i <= wqpc_pkg::TempColdLo) begin
      cold_mu = wqpc_pkg::FullScale;
    end else if (temp_i >= wqpc_pkg::TempColdHi) begin
      cold_mu = '0;
    end else begin
      cold_mu = cold_prod[12:5];
    end
  end

  assign base_x    = 8'(ph_o - wqpc_pkg::PhBaseLo);
  assign base_prod = 16'(base_x) * 16'd255;
  always_comb begin
    if (ph_o <= wqpc_pkg::PhBaseLo) begin
      base_mu = '0;
    end else if (ph_o >= wqpc_pkg::PhBaseHi) begin
      base_mu = wqpc_pkg::FullScale;
    end else begin
      base_mu = base_prod[15:8];
    end
  end

  assign acid_x    = 9'(wqpc_pkg::PhAcidHi - ph_o);
  assign acid_prod = 17'(acid_x) * 17'd255;
  always_comb begin
    if (ph_o <= wqpc_pkg::PhAcidLo) begin
      acid_mu = wqpc_pkg::FullScale;
    end else if (ph_o >= wqpc_pkg::PhAcidHi) begin
      acid_mu = '0;
    end else begin
      acid_mu = acid_prod[16:9];
    end
  end

  assign duty_o.cooling = gate_duty(hot_mu, threshold_i);
  assign duty_o.warming = gate_duty(cold_mu, threshold_i);
  assign duty_o.acid    = gate_duty(base_mu, threshold_i);
  assign duty_o.alkali  = gate_duty(acid_mu, threshold_i);

endmodule

// ===== hw/rtl/wqpc_fill.sv =====
// Fill relay sequencer: turbidity history and timed fill after clearing.
module wqpc_fill (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         advance_i,
  input  logic                         clear_i,
  input  logic [wqpc_pkg::TimeW-1:0]   time_i,
  input  logic [wqpc_pkg::DurW-1:0]    duration_i,
  output logic                         relay_o
);

  logic                       was_turbid_q, was_turbid_d;
  logic                       filling_q, filling_d;
  logic [wqpc_pkg::TimeW-1:0] start_q, start_d;
  logic                       begin_fill;
  logic                       fill_run;
  logic [wqpc_pkg::TimeW-1:0] elapsed;
  logic                       expired;

  always_comb begin
    begin_fill = clear_i & was_turbid_q & ~filling_q;
    fill_run   = filling_q | begin_fill;
    start_d    = begin_fill ? time_i : start_q;
    elapsed    = time_i - start_d;
    expired    = elapsed >= wqpc_pkg::TimeW'(duration_i);
    if (clear_i) begin
      filling_d    = fill_run & ~expired;
      was_turbid_d = 1'b0;
      relay_o      = filling_d;
    end else begin
      filling_d    = 1'b0;
      was_turbid_d = 1'b1;
      relay_o      = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_turbid_q <= 1'b0;
      filling_q    <= 1'b0;
      start_q      <= '0;
    end else if (advance_i) begin
      was_turbid_q <= was_turbid_d;
      filling_q    <= filling_d;
      start_q      <= start_d;
    end
  end

  a_fill_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(filling_q && was_turbid_q))
    else $error("fill running while turbid flag set");

  a_turbid_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && !clear_i) |=> (was_turbid_q && !filling_q))
    else $error("turbid sample did not reset fill state");

  a_start_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance_i && $past(advance_i) && filling_q && clear_i) |=> $stable(start_q))
    else $error("fill start time changed during a running fill");

endmodule

// ===== hw/rtl/fuzzy_water_quality_pump_control.sv =====
// Top level of the fuzzy water quality pump controller.
//
// Usage:
//   Input channel: in_valid_i with in_stall_o; one sample per transfer carrying
//   temperature, pH converter count, turbidity bit and millisecond timestamp.
//   Output channel: out_valid_o with out_stall_i; one result per sample with four
//   pump duties, the fill relay bit and the computed pH.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
//   index 0 is the pump threshold, index 1 the fill duration in ms. Always ready.
//   A transferred sample is held in the input register, with all arithmetic between
//   it and the result register. Throughput: one sample per cycle when not stalled,
//   set by the single input register and the single result register.
//   Reset clears both valid flags, the fill state and restores threshold 20 and
//   duration 10000 ms.
//   When the receiver stalls, the result holds; the input register still takes
//   one more sample, after which in_stall_o rises until the result is taken.
module fuzzy_water_quality_pump_control (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [wqpc_pkg::TempW-1:0] temperature_sixteenths_i,
  input  logic        [wqpc_pkg::AdcW-1:0]  ph_adc_count_i,
  input  logic                              water_clear_i,
  input  logic        [wqpc_pkg::TimeW-1:0] time_ms_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic        [wqpc_pkg::DutyW-1:0] cooling_pump_duty_o,
  output logic        [wqpc_pkg::DutyW-1:0] warming_pump_duty_o,
  output logic        [wqpc_pkg::DutyW-1:0] acid_pump_duty_o,
  output logic        [wqpc_pkg::DutyW-1:0] alkali_pump_duty_o,
  output logic                              fill_relay_on_o,
  output logic        [wqpc_pkg::PhW-1:0]   ph_hundredths_q8_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wqpc_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wqpc_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic                              s1_valid_q, s1_valid_d;
  logic signed [wqpc_pkg::TempW-1:0] s1_temp_q;
  logic        [wqpc_pkg::AdcW-1:0]  s1_adc_q;
  logic                              s1_clear_q;
  logic        [wqpc_pkg::TimeW-1:0] s1_time_q;
  logic                              s1_adv;
  logic                              in_load;

  logic                              out_valid_q, out_valid_d;
  wqpc_pkg::duty_t                   out_duty_q;
  logic                              out_relay_q;
  logic        [wqpc_pkg::PhW-1:0]   out_ph_q;

  logic [wqpc_pkg::ThreshW-1:0]      threshold_q;
  logic [wqpc_pkg::DurW-1:0]         duration_q;

  wqpc_pkg::duty_t                   duty;
  logic        [wqpc_pkg::PhW-1:0]   ph;
  logic                              relay;

  assign s1_adv     = s1_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_load    = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      threshold_q <= wqpc_pkg::ThreshReset;
      duration_q  <= wqpc_pkg::DurReset;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          wqpc_pkg::CfgPwmThreshold: threshold_q <= cfg_data_i[wqpc_pkg::ThreshW-1:0];
          wqpc_pkg::CfgFillDuration: duration_q  <= cfg_data_i[wqpc_pkg::DurW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      s1_temp_q  <= temperature_sixteenths_i;
      s1_adc_q   <= ph_adc_count_i;
      s1_clear_q <= water_clear_i;
      s1_time_q  <= time_ms_i;
    end
    if (s1_adv) begin
      out_duty_q  <= duty;
      out_relay_q <= relay;
      out_ph_q    <= ph;
    end
  end

  wqpc_calc u_calc (
    .temp_i      (s1_temp_q),
    .adc_i       (s1_adc_q),
    .threshold_i (threshold_q),
    .duty_o      (duty),
    .ph_o        (ph)
  );

  wqpc_fill u_fill (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (s1_adv),
    .clear_i    (s1_clear_q),
    .time_i     (s1_time_q),
    .duration_i (duration_q),
    .relay_o    (relay)
  );

  assign out_valid_o         = out_valid_q;
  assign cooling_pump_duty_o = out_duty_q.cooling;
  assign warming_pump_duty_o = out_duty_q.warming;
  assign acid_pump_duty_o    = out_duty_q.acid;
  assign alkali_pump_duty_o  = out_duty_q.alkali;
  assign fill_relay_on_o     = out_relay_q;
  assign ph_hundredths_q8_o  = out_ph_q;

  a_turbid_relay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && !s1_clear_q) |=> (out_valid_o && fill_relay_on_o))
    else $error("turbid sample did not turn the fill relay on");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled without a held sample and result");

  a_duty_gate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (duty.cooling != '0) |-> (duty.cooling > threshold_q))
    else $error("cooling duty passed at or below threshold");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking bench for the fuzzy water quality pump controller: memberships, relay, registers.
module tb_top;

  localparam int ColdLo = 256;
  localparam int ColdHi = 416;
  localparam int HotLo = 480;
  localparam int HotHi = 544;
  localparam int AcidLo = 1152;
  localparam int AcidHi = 1664;
  localparam int BaseLo = 1920;
  localparam int BaseHi = 2176;
  localparam int PhOffset = 5348;
  localparam int unsigned PhSlope = 37557;
  localparam int QuietLimit = 1000;
  localparam int DrainCycles = 4;

  typedef struct packed {
    wqpc_pkg::duty_t              duty;
    logic                         relay;
    logic [wqpc_pkg::PhW-1:0]     ph;
  } pump_result_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic signed [wqpc_pkg::TempW-1:0] temperature_sixteenths_i = '0;
  logic [wqpc_pkg::AdcW-1:0]         ph_adc_count_i = '0;
  logic                              water_clear_i = 1'b1;
  logic [wqpc_pkg::TimeW-1:0]        time_ms_i = '0;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic [wqpc_pkg::DutyW-1:0]        cooling_pump_duty_o;
  logic [wqpc_pkg::DutyW-1:0]        warming_pump_duty_o;
  logic [wqpc_pkg::DutyW-1:0]        acid_pump_duty_o;
  logic [wqpc_pkg::DutyW-1:0]        alkali_pump_duty_o;
  logic                              fill_relay_on_o;
  logic [wqpc_pkg::PhW-1:0]          ph_hundredths_q8_o;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [wqpc_pkg::CfgIdxW-1:0]      cfg_index_i = wqpc_pkg::CfgPwmThreshold;
  logic [wqpc_pkg::CfgDataW-1:0]     cfg_data_i = '0;

  logic [wqpc_pkg::ThreshW-1:0] threshold_q = 8'd20;
  logic [wqpc_pkg::DurW-1:0]    fill_dur_q = 20'd10000;
  logic                         turbid_seen = 1'b0;
  logic                         fill_active = 1'b0;
  logic [wqpc_pkg::TimeW-1:0]   fill_start = '0;
  logic [wqpc_pkg::TimeW-1:0]   clock_ms = '0;

  pump_result_t expected_q[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int sink_hold_left = 0;
  int mismatches = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int fills_expired = 0;
  int quiet_cycles = 0;

  fuzzy_water_quality_pump_control dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int ramp_rise(int x, int lo, int hi);
    if (x <= lo) return 0;
    if (x >= hi) return 255;
    return (x - lo) * 255 / (hi - lo);
  endfunction

  function automatic int ramp_fall(int x, int lo, int hi);
    if (x <= lo) return 255;
    if (x >= hi) return 0;
    return (hi - x) * 255 / (hi - lo);
  endfunction

  function automatic logic [wqpc_pkg::DutyW-1:0] gate_duty(int d);
    return (d > threshold_q) ? d[wqpc_pkg::DutyW-1:0] : '0;
  endfunction

  function automatic pump_result_t predict_pumps(logic signed [wqpc_pkg::TempW-1:0] temp,
                                                 logic [wqpc_pkg::AdcW-1:0] adc,
                                                 logic clear,
                                                 logic [wqpc_pkg::TimeW-1:0] stamp);
    pump_result_t               r;
    int                         t;
    int                         ph;
    int unsigned                prod;
    logic [wqpc_pkg::TimeW-1:0] elapsed;
    t = temp;
    prod = adc;
    prod = prod * PhSlope;
    ph = PhOffset - int'(prod >> 15);
    if (clear) begin
      if (turbid_seen && !fill_active) begin
        fill_active = 1'b1;
        fill_start = stamp;
      end
      elapsed = stamp - fill_start;
      if (fill_active && elapsed >= fill_dur_q) begin
        fill_active = 1'b0;
        fills_expired++;
      end
      turbid_seen = 1'b0;
      r.relay = fill_active;
    end else begin
      fill_active = 1'b0;
      turbid_seen = 1'b1;
      r.relay = 1'b1;
    end
    r.duty.cooling = gate_duty(ramp_rise(t, HotLo, HotHi));
    r.duty.warming = gate_duty(ramp_fall(t, ColdLo, ColdHi));
    r.duty.acid = gate_duty(ramp_rise(ph, BaseLo, BaseHi));
    r.duty.alkali = gate_duty(ramp_fall(ph, AcidLo, AcidHi));
    r.ph = ph[wqpc_pkg::PhW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_checked, name, got, want));
  endtask

  task automatic check_result();
    pump_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch("result with no sample outstanding");
      return;
    end
    want = expected_q.pop_front();
    results_checked++;
    compare_field("cooling_pump_duty", cooling_pump_duty_o, want.duty.cooling);
    compare_field("warming_pump_duty", warming_pump_duty_o, want.duty.warming);
    compare_field("acid_pump_duty", acid_pump_duty_o, want.duty.acid);
    compare_field("alkali_pump_duty", alkali_pump_duty_o, want.duty.alkali);
    compare_field("fill_relay_on", fill_relay_on_o, want.relay);
    compare_field("ph_hundredths_q8", ph_hundredths_q8_o, want.ph);
  endtask

  // track every transfer at the rising edge and guard against a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == wqpc_pkg::CfgPwmThreshold) begin
          threshold_q = cfg_data_i[wqpc_pkg::ThreshW-1:0];
        end else begin
          fill_dur_q = cfg_data_i[wqpc_pkg::DurW-1:0];
        end
        cfg_writes++;
      end
      if (out_valid_o && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_pumps(temperature_sixteenths_i, ph_adc_count_i,
                                           water_clear_i, time_ms_i));
        samples_sent++;
      end
      if ((cfg_valid_i && cfg_ready_o) || (out_valid_o && !out_stall_i) ||
          (in_valid_i && !in_stall_o)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: %0d cycles without a transfer, %0d results pending",
                 quiet_cycles, expected_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // hold off the output for a counted stretch, else stall at random
  always @(negedge clk_i) begin
    if (sink_hold_left > 0) begin
      out_stall_i <= 1'b1;
      sink_hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_idle_pct);
    end
  end

  task automatic send_sample(int temp, int adc, logic clear,
                             logic [wqpc_pkg::TimeW-1:0] stamp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    temperature_sixteenths_i = temp[wqpc_pkg::TempW-1:0];
    ph_adc_count_i = adc[wqpc_pkg::AdcW-1:0];
    water_clear_i = clear;
    time_ms_i = stamp;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(logic [wqpc_pkg::CfgIdxW-1:0] idx, int unsigned value);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = value[wqpc_pkg::CfgDataW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_field_sample(logic clear);
    int temp;
    int adc;
    temp = ($urandom_range(1) == 1) ? $urandom_range(200, 600) : $urandom_range(4095);
    adc = ($urandom_range(1) == 1) ? $urandom_range(2600, 3800) : $urandom_range(4095);
    clock_ms += $urandom_range(0, 50);
    send_sample(temp, adc, clear, clock_ms);
  endtask

  // turbid run followed by clear samples; some noise and wrapping clocks mixed in
  task automatic run_episode();
    int pick;
    int turbid_n;
    int clear_n;
    pick = $urandom_range(99);
    if (pick < 12) begin
      clock_ms = $urandom();
      send_sample($urandom_range(4095), $urandom_range(4095), 1'($urandom_range(1)),
                  clock_ms);
    end else begin
      if (pick < 18) clock_ms = 32'hFFFF_FFFF - $urandom_range(300);
      turbid_n = $urandom_range(0, 3);
      clear_n = $urandom_range(1, 6);
      repeat (turbid_n) send_field_sample(1'b0);
      repeat (clear_n) send_field_sample(1'b1);
    end
  endtask

  task automatic test_membership_edges();
    int temps[10] = '{-2048, 2047, 256, 257, 416, 480, 481, 544, -880, 2000};
    int adcs[10] = '{0, 4095, 2767, 2991, 3214, 3661, 2990, 3660, 1000, 3900};
    for (int i = 0; i < 10; i++) send_sample(temps[i], adcs[i], 1'b1, 32'd0);
  endtask

  task automatic test_fill_timing();
    logic [wqpc_pkg::TimeW-1:0] t0;
    t0 = 32'd5000;
    send_sample(300, 3000, 1'b0, 32'd1000);
    send_sample(300, 3000, 1'b1, t0);
    send_sample(300, 3000, 1'b1, t0 + fill_dur_q - 1);
    send_sample(300, 3000, 1'b1, t0 + fill_dur_q);
    t0 = 32'hFFFF_FFF0;
    send_sample(500, 2800, 1'b0, t0 - 32'd16);
    send_sample(500, 2800, 1'b1, t0);
    send_sample(500, 2800, 1'b1, 32'h0000_0100);
    send_sample(500, 2800, 1'b1, t0 + fill_dur_q);
  endtask

  task automatic test_fill_duration_limits();
    wait_idle();
    write_register(wqpc_pkg::CfgFillDuration, 0);
    send_sample(100, 3300, 1'b0, 32'd40);
    send_sample(100, 3300, 1'b1, 32'd40);
    wait_idle();
    write_register(wqpc_pkg::CfgFillDuration, 20'hFFFFF);
    send_sample(600, 2000, 1'b0, 32'd0);
    send_sample(600, 2000, 1'b1, 32'd7);
    send_sample(600, 2000, 1'b1, 32'd7 + 32'hFFFFE);
    send_sample(600, 2000, 1'b1, 32'd7 + 32'hFFFFF);
  endtask

  task automatic test_threshold_limits();
    wait_idle();
    write_register(wqpc_pkg::CfgPwmThreshold, 255);
    send_sample(-880, 4095, 1'b1, 32'd0);
    send_sample(2000, 0, 1'b1, 32'd0);
    wait_idle();
    write_register(wqpc_pkg::CfgPwmThreshold, 0);
    send_sample(481, 2992, 1'b1, 32'd0);
    send_sample(415, 3662, 1'b1, 32'd0);
  endtask

  task automatic test_random_traffic(int src_pct, int sink_pct, int unsigned thresh,
                                     int unsigned dur, int count);
    int target;
    wait_idle();
    write_register(wqpc_pkg::CfgPwmThreshold, thresh);
    write_register(wqpc_pkg::CfgFillDuration, dur);
    src_idle_pct = src_pct;
    sink_idle_pct = sink_pct;
    target = samples_sent + count;
    while (samples_sent < target) run_episode();
  endtask

  // hold the output long enough that the input side backs up
  task automatic test_output_backpressure();
    wait_idle();
    src_idle_pct = 0;
    sink_idle_pct = 0;
    sink_hold_left = 60;
    repeat (12) send_field_sample(1'($urandom_range(1)));
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_membership_edges();
    test_fill_timing();
    test_fill_duration_limits();
    test_threshold_limits();
    test_random_traffic(9, 64, $urandom_range(0, 60), $urandom_range(20, 150), 150);
    test_random_traffic(64, 9, 0, $urandom_range(0, 40), 150);
    test_output_backpressure();
    test_random_traffic(0, 0, $urandom_range(0, 254), $urandom_range(1, 150), 150);
    wait_idle();
    $display("summary: %0d samples, %0d results checked, %0d register writes, %0d fills ran out",
             samples_sent, results_checked, cfg_writes, fills_expired);
    $display("summary: %0d mismatches over three idling patterns and one long output hold",
             mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/wqpc_pkg.sv
hw/rtl/wqpc_calc.sv
hw/rtl/wqpc_fill.sv
hw/rtl/fuzzy_water_quality_pump_control.sv
verif/tb_top.sv
